/* design/tcw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// operation codes, character codes, controller states and the command and
// status groups between controller and datapath
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam logic [7:0] NEWLINE_CODE = 8'd10;
	localparam logic [7:0] SPACE_CODE   = 8'd32;
	localparam logic [7:0] ATTR_RESET   = 8'd15;

	typedef enum logic [1:0] {
		OP_PRINT = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	// what a store sweep writes into each cell
	typedef enum logic [1:0] {
		SW_ZERO = 2'd0,
		SW_FILL = 2'd1,
		SW_COPY = 2'd2
	} sweep_mode_t;

	typedef enum logic [2:0] {
		ST_INIT   = 3'd0,
		ST_IDLE   = 3'd1,
		ST_EXEC   = 3'd2,
		ST_SCROLL = 3'd3,
		ST_FILL   = 3'd4,
		ST_DONE   = 3'd5
	} state_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] char_code;
		logic       use_cursor;
		logic [6:0] column;
		logic [4:0] line;
		logic [7:0] attribute;
	} item_t;

	typedef struct packed {
		logic [10:0] cursor_cell;
		logic [7:0]  read_char;
		logic [7:0]  read_attr;
	} result_t;

	typedef struct packed {
		logic        load;
		logic        exec;
		logic        sweep_clr;
		logic        sweep_run;
		sweep_mode_t mode;
	} dp_cmd_t;

	typedef struct packed {
		op_t  op;
		logic scroll;
		logic sweep_last;
	} dp_sts_t;

endpackage

/* design/tcw_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw interfaces: valid/ready channels of the text console writer
// command channel, response channel and configuration write channel
// ----------------------------------------------------------------------------
interface tcw_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] char_code;
	logic       use_cursor;
	logic [6:0] column;
	logic [4:0] line;
	logic [7:0] attribute;

	modport source (output valid, op, char_code, use_cursor, column, line, attribute,
		input ready);
	modport sink (input valid, op, char_code, use_cursor, column, line, attribute,
		output ready);
endinterface

interface tcw_rsp_if;
	logic        valid;
	logic        ready;
	logic [10:0] cursor_cell;
	logic [7:0]  read_char;
	logic [7:0]  read_attr;

	modport source (output valid, cursor_cell, read_char, read_attr, input ready);
	modport sink (input valid, cursor_cell, read_char, read_attr, output ready);
endinterface

interface tcw_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

/* design/text_console_writer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer: character-cell text console with scroll and clear
// keeps a COLS x ROWS store of character and attribute bytes and a cursor
// ----------------------------------------------------------------------------
// a command is loaded on accept, then executed, then its response is registered
// print that scrolls and clear first sweep all COLS*ROWS cells, one cell per
//   cycle, through the single write port of the screen store
// one transaction in flight; the next command is taken once the response is
//   registered, while that response still waits on the response channel
// reset: a blanking sweep writes zero to all COLS*ROWS cells, one per cycle,
//   and cmd.ready stays low until the sweep reaches the last cell; config writes
//   always go
// ----------------------------------------------------------------------------
module text_console_writer #(
	parameter int COLS = 80,
	parameter int ROWS = 25
) (
	input logic       clk,
	input logic       arst_n,
	tcw_cmd_if.sink   cmd,
	tcw_rsp_if.source rsp,
	tcw_cfg_if.sink   cfg
);
	import tcw_pkg::*;

	localparam int CELLS = COLS * ROWS;

	item_t   item;
	dp_cmd_t ctl;
	dp_sts_t sts;
	result_t result;
	result_t rsp_data_q;
	logic    rsp_valid_q;
	logic    out_free;
	logic    rsp_load;
	logic    cmd_ready;

	// gather the command payload into one word
	assign item = '{op: cmd.op, char_code: cmd.char_code, use_cursor: cmd.use_cursor,
		column: cmd.column, line: cmd.line, attribute: cmd.attribute};

	assign cmd.ready = cmd_ready;

	// the register is always writable
	assign cfg.ready = 1'b1;

	// response register is free when empty or being drained this cycle
	assign out_free = !rsp_valid_q || rsp.ready;

	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.out_free  (out_free),
		.sts       (sts),
		.ctl       (ctl),
		.cmd_ready (cmd_ready),
		.rsp_load  (rsp_load)
	);

	tcw_datapath #(
		.COLS (COLS),
		.ROWS (ROWS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cfg_we   (cfg.valid),
		.cfg_data (cfg.data),
		.ctl      (ctl),
		.sts      (sts),
		.result   (result)
	);

	// response output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_data_q <= result;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.cursor_cell = rsp_data_q.cursor_cell;
	assign rsp.read_char   = rsp_data_q.read_char;
	assign rsp.read_attr   = rsp_data_q.read_attr;

	// one transaction at a time: no command taken in the cycle after one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd_ready |=> !cmd_ready)
		else $error("command accepted while previous one still executing");

	// a new response never overwrites one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |-> (!rsp_valid_q || rsp.ready))
		else $error("response register overwritten");

	// the cursor always sits inside the screen
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |-> ((CELLS > 2048) || (int'(result.cursor_cell) < CELLS)))
		else $error("cursor outside the screen");

endmodule

/* design/tcw_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_datapath: screen store, cursor and sweep engine
// one write and one registered read of the store per cycle
// ----------------------------------------------------------------------------
module tcw_datapath #(
	parameter int COLS = 80,
	parameter int ROWS = 25
) (
	input  logic            clk,
	input  logic            arst_n,
	input  tcw_pkg::item_t  item,
	input  logic            cfg_we,
	input  logic [7:0]      cfg_data,
	input  tcw_pkg::dp_cmd_t ctl,
	output tcw_pkg::dp_sts_t sts,
	output tcw_pkg::result_t result
);
	import tcw_pkg::*;

	localparam int CELLS  = COLS * ROWS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int COL_W  = $clog2(COLS);
	localparam int ROW_W  = $clog2(ROWS);

	logic [15:0]       screen_q [CELLS];
	logic [15:0]       rd_q;
	item_t             item_q;
	logic [7:0]        def_attr_q;
	logic [COL_W-1:0]  cur_col_q;
	logic [ROW_W-1:0]  cur_row_q;
	logic [ADDR_W-1:0] sweep_q;
	logic              read_hit_q;
	logic              sweep_vld_s1;
	logic [ADDR_W-1:0] sweep_addr_s1;
	sweep_mode_t       sweep_mode_s1;

	logic              in_range, print_ok, is_nl, wrap, last_row, cell_we;
	logic              is_print, is_read, is_clear, re, copy_src;
	logic [COL_W-1:0]  pos_col;
	logic [ROW_W-1:0]  pos_row;
	logic [ADDR_W-1:0] given_addr, cur_addr, pos_addr, wa, ra;
	logic [15:0]       wd;
	logic [7:0]        attr_eff;

	always_comb begin
		is_print = item_q.op == OP_PRINT;
		is_read  = item_q.op == OP_READ;
		is_clear = item_q.op == OP_CLEAR;
		in_range = ({1'b0, item_q.column} < 8'(COLS)) && ({2'b0, item_q.line} < 7'(ROWS));
		pos_col  = item_q.use_cursor ? cur_col_q : COL_W'(item_q.column);
		pos_row  = item_q.use_cursor ? cur_row_q : ROW_W'(item_q.line);
		print_ok = item_q.use_cursor || in_range;
		is_nl    = item_q.char_code == NEWLINE_CODE;
		wrap     = is_nl || (pos_col == COL_W'(COLS - 1));
		last_row = pos_row == ROW_W'(ROWS - 1);
		attr_eff = (item_q.attribute == 8'd0) ? def_attr_q : item_q.attribute;

		given_addr = ADDR_W'(ROW_W'(item_q.line)) * ADDR_W'(COLS)
			+ ADDR_W'(COL_W'(item_q.column));
		cur_addr   = ADDR_W'(cur_row_q) * ADDR_W'(COLS) + ADDR_W'(cur_col_q);
		pos_addr   = item_q.use_cursor ? cur_addr : given_addr;

		// only rows below the top one are copied; the last row is blanked
		copy_src = sweep_q < ADDR_W'(CELLS - COLS);

		cell_we = ctl.exec && is_print && print_ok && !is_nl;
		if (cell_we) begin
			wa = pos_addr;
			wd = {item_q.char_code, attr_eff};
		end else begin
			wa = sweep_addr_s1;
			case (sweep_mode_s1)
				SW_FILL: wd = {SPACE_CODE, def_attr_q};
				SW_COPY: wd = rd_q;
				default: wd = 16'd0;
			endcase
		end

		re = (ctl.exec && is_read && in_range)
			|| (ctl.sweep_run && ctl.mode == SW_COPY && copy_src);
		ra = ctl.exec ? given_addr : sweep_q + ADDR_W'(COLS);

		sts.op         = op_t'(item_q.op);
		sts.scroll     = print_ok && wrap && last_row;
		sts.sweep_last = sweep_q == ADDR_W'(CELLS - 1);

		result.cursor_cell = 11'(cur_addr);
		result.read_char   = read_hit_q ? rd_q[15:8] : 8'd0;
		result.read_attr   = read_hit_q ? rd_q[7:0] : 8'd0;
	end

	// screen store
	always_ff @(posedge clk) begin
		if (cell_we || sweep_vld_s1) begin
			screen_q[wa] <= wd;
		end
		if (re) begin
			rd_q <= screen_q[ra];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			item_q <= item;
		end
		if (ctl.exec) begin
			read_hit_q <= is_read && in_range;
		end
		sweep_addr_s1 <= sweep_q;
		sweep_mode_s1 <= (ctl.mode == SW_COPY && !copy_src) ? SW_ZERO : ctl.mode;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_attr_q   <= ATTR_RESET;
			cur_col_q    <= '0;
			cur_row_q    <= '0;
			sweep_q      <= '0;
			sweep_vld_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				def_attr_q <= cfg_data;
			end
			sweep_vld_s1 <= ctl.sweep_run;
			if (ctl.sweep_clr) begin
				sweep_q <= '0;
			end else if (ctl.sweep_run) begin
				sweep_q <= sweep_q + 1'b1;
			end
			if (ctl.exec && is_print && print_ok) begin
				if (wrap) begin
					cur_col_q <= '0;
					cur_row_q <= last_row ? pos_row : pos_row + 1'b1;
				end else begin
					cur_col_q <= pos_col + 1'b1;
					cur_row_q <= pos_row;
				end
			end else if (ctl.exec && is_clear) begin
				cur_col_q <= '0;
				cur_row_q <= '0;
			end
		end
	end

endmodule

/* design/tcw_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ctrl: controller of the text console writer
// sequences reset blanking, item execution, scroll and clear sweeps
// ----------------------------------------------------------------------------
module tcw_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  logic             out_free,
	input  tcw_pkg::dp_sts_t sts,
	output tcw_pkg::dp_cmd_t ctl,
	output logic             cmd_ready,
	output logic             rsp_load
);
	import tcw_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		ctl.mode  = SW_ZERO;
		cmd_ready = 1'b0;
		rsp_load  = 1'b0;
		case (state_q)
			ST_INIT: begin
				ctl.sweep_run = 1'b1;
				ctl.mode      = SW_ZERO;
				if (sts.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					ctl.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				ctl.exec      = 1'b1;
				ctl.sweep_clr = 1'b1;
				case (sts.op)
					OP_PRINT: state_d = sts.scroll ? ST_SCROLL : ST_DONE;
					OP_CLEAR: state_d = ST_FILL;
					default:  state_d = ST_DONE;
				endcase
			end
			ST_SCROLL: begin
				ctl.sweep_run = 1'b1;
				ctl.mode      = SW_COPY;
				if (sts.sweep_last) begin
					state_d = ST_DONE;
				end
			end
			ST_FILL: begin
				ctl.sweep_run = 1'b1;
				ctl.mode      = SW_FILL;
				if (sts.sweep_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
